### rtl/vcpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vcpg_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MODE_CONTROL     = 2'd0,
      CSR_COLOR_SELECT     = 2'd1,
      CSR_MODE_CONTROL_TWO = 2'd2,
      CSR_MONOCHROME       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] mode_control;
      logic [7:0] color_select;
      logic [7:0] mode_control_two;
      logic       monochrome;
   } cfg_type;

   // one classified cell: pixel bits msb first, a four-entry colour palette
   typedef struct packed {
      logic [15:0]     data;
      logic [3:0][3:0] pal;
      logic            two_bit;
      logic            wide;
   } item_type;

   function automatic logic [23:0] rgbi_color(input logic [3:0] c);
      logic [23:0] v;
      case (c)
         4'd0:    v = 24'h000000;
         4'd1:    v = 24'h0000aa;
         4'd2:    v = 24'h00aa00;
         4'd3:    v = 24'h00aaaa;
         4'd4:    v = 24'haa0000;
         4'd5:    v = 24'haa00aa;
         4'd6:    v = 24'haa5500;
         4'd7:    v = 24'haaaaaa;
         4'd8:    v = 24'h555555;
         4'd9:    v = 24'h5555ff;
         4'd10:   v = 24'h55ff55;
         4'd11:   v = 24'h55ffff;
         4'd12:   v = 24'hff5555;
         4'd13:   v = 24'hff55ff;
         4'd14:   v = 24'hffff55;
         default: v = 24'hffffff;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] gray_level(input logic [3:0] c);
      logic [7:0] v;
      case (c)
         4'd0:    v = 8'h00;
         4'd1:    v = 8'h18;
         4'd2:    v = 8'h30;
         4'd3:    v = 8'h48;
         4'd4:    v = 8'h60;
         4'd5:    v = 8'h78;
         4'd6:    v = 8'h90;
         4'd7:    v = 8'haa;
         4'd8:    v = 8'h55;
         4'd9:    v = 8'h6d;
         4'd10:   v = 8'h85;
         4'd11:   v = 8'h9d;
         4'd12:   v = 8'hb6;
         4'd13:   v = 8'hce;
         4'd14:   v = 8'he6;
         default: v = 8'hff;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/vcpg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vcpg_front (
   input  wire vcpg_pkg::cfg_type  cfg,
   input  wire logic [7:0]         first_byte,
   input  wire logic [7:0]         second_byte,
   input  wire logic [7:0]         font_row,
   input  wire logic [3:0]         scan_row,
   input  wire logic               cursor_here,
   input  wire logic [7:0]         cursor_bits,
   input  wire logic               blink_phase,
   output vcpg_pkg::item_type      item
);
   import vcpg_pkg::*;

   logic [7:0] attr;
   logic [7:0] bits;
   logic       ul;
   logic [3:0] base1, base2, base3;

   // text attribute handling
   always_comb begin
      attr = second_byte;
      bits = font_row;
      ul   = (cfg.monochrome && cfg.mode_control[2]) || cfg.mode_control_two[6];
      if (cfg.mode_control[5] && attr[7]) begin
         if (!blink_phase) begin
            attr = {1'b0, attr[6:4], 1'b0, attr[6:4]};
         end
         attr[7] = 1'b0;
      end
      if (ul && attr[2:0] == 3'd1) begin
         if (cfg.monochrome) begin
            attr[2:0] = 3'd7;
         end
         if (scan_row == 4'd14) begin
            bits = 8'hff;
         end
      end
      if (cursor_here && blink_phase) begin
         bits = bits | cursor_bits;
      end
   end

   // 320 palette
   always_comb begin
      if (cfg.mode_control[2]) begin
         base1 = 4'd3; base2 = 4'd4; base3 = 4'd7;
      end else if (cfg.color_select[5]) begin
         base1 = 4'd3; base2 = 4'd5; base3 = 4'd7;
      end else begin
         base1 = 4'd2; base2 = 4'd4; base3 = 4'd6;
      end
      if (cfg.color_select[4]) begin
         base1 = base1 | 4'd8;
         base2 = base2 | 4'd8;
         base3 = base3 | 4'd8;
      end
   end

   always_comb begin
      item = '0;
      if (!cfg.mode_control[3]) begin
         item.data = 16'h0000;
      end else if (cfg.mode_control[1] && cfg.mode_control[4]) begin
         item.data   = {first_byte, second_byte};
         item.pal[0] = 4'd0;
         item.pal[1] = cfg.color_select[3:0];
         item.wide   = 1'b1;
      end else if (cfg.mode_control[1]) begin
         item.data    = {first_byte, second_byte};
         item.pal[0]  = cfg.color_select[3:0];
         item.pal[1]  = base1;
         item.pal[2]  = base2;
         item.pal[3]  = base3;
         item.two_bit = 1'b1;
      end else begin
         item.data   = {bits, 8'h00};
         item.pal[0] = attr[7:4];
         item.pal[1] = attr[3:0];
      end
   end

endmodule
`default_nettype wire

### rtl/vcpg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module vcpg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire vcpg_pkg::item_type in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output vcpg_pkg::item_type      out_item
);
   import vcpg_pkg::*;

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push, pop;

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

### rtl/vcpg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vcpg_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               monochrome,
   input  wire logic               q_valid,
   output logic                    q_ready,
   input  wire vcpg_pkg::item_type q_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic                    rsp_last_pixel
);
   import vcpg_pkg::*;

   item_type    item_ff, item_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        active_ff, active_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic        last_ff;
   logic        advance, last_now, load;
   logic [1:0]  idx;
   logic [3:0]  color;
   logic [23:0] rgb;
   item_type    shifted;

   always_comb begin
      advance  = active_ff && (!rsp_valid_ff || rsp_ready);
      last_now = cnt_ff == 4'd0;
      load     = q_valid && (!active_ff || (advance && last_now));
      idx      = item_ff.two_bit ? item_ff.data[15:14] : {1'b0, item_ff.data[15]};
      color    = item_ff.pal[idx];
      if (monochrome) begin
         rgb = {3{gray_level(color)}};
      end else begin
         rgb = rgbi_color(color);
      end
      shifted      = item_ff;
      shifted.data = item_ff.two_bit ? {item_ff.data[13:0], 2'b00}
                                     : {item_ff.data[14:0], 1'b0};
      item_in   = item_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      if (load) begin
         item_in   = q_item;
         cnt_in    = q_item.wide ? 4'd15 : 4'd7;
         active_in = 1'b1;
      end else if (advance) begin
         item_in   = shifted;
         cnt_in    = cnt_ff - 4'd1;
         active_in = !last_now;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign q_ready        = load;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_last_pixel = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      cnt_ff  <= cnt_in;
      if (advance) begin
         red_ff   <= rgb[23:16];
         green_ff <= rgb[15:8];
         blue_ff  <= rgb[7:0];
         last_ff  <= last_now;
      end
   end

`ifndef NO_ASSERTIONS
   a_narrow_count: assert property (@(posedge clock) disable iff (reset)
      active_ff && !item_ff.wide |-> cnt_ff <= 4'd7)
      else $error("pixel count out of range for an 8 pixel cell");
   a_no_stray_load: assert property (@(posedge clock) disable iff (reset)
      active_ff && !(advance && last_now) |-> !q_ready)
      else $error("cell loaded while one is still in progress");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      advance && last_now && !q_valid |=> !active_ff)
      else $error("back end stayed busy after the last pixel");
`endif

endmodule
`default_nettype wire

### rtl/video_cell_pixel_generator_unit.sv
// with the back end idle, an accepted cell goes from its queue entry into the back end's
// cell register, and its first pixel is then registered onto the rsp outputs
// throughput: one pixel per cycle while rsp_ready is high; a cell has 8 pixels, or 16 in
// the 640 mode, from the back end's pixel shifter; the 2-entry queue takes up to two more
// transactions while a cell is shifted out, then req_ready drops until a cell is loaded
// reset (synchronous, active high) clears the mode registers, the queue and rsp_valid
`timescale 1ns / 1ps
`default_nettype none
module video_cell_pixel_generator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_first_byte,
   input  wire logic [7:0]  req_second_byte,
   input  wire logic [7:0]  req_font_row,
   input  wire logic [3:0]  req_scan_row,
   input  wire logic        req_cursor_here,
   input  wire logic [7:0]  req_cursor_bits,
   input  wire logic        req_blink_phase,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_last_pixel,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);
   import vcpg_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type front_item;
   item_type q_item;
   logic     q_valid, q_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE_CONTROL:     cfg_in.mode_control     = csr_write_data;
            CSR_COLOR_SELECT:     cfg_in.color_select     = csr_write_data;
            CSR_MODE_CONTROL_TWO: cfg_in.mode_control_two = csr_write_data;
            CSR_MONOCHROME:       cfg_in.monochrome       = csr_write_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vcpg_front u_front (
      .cfg         (cfg_ff),
      .first_byte  (req_first_byte),
      .second_byte (req_second_byte),
      .font_row    (req_font_row),
      .scan_row    (req_scan_row),
      .cursor_here (req_cursor_here),
      .cursor_bits (req_cursor_bits),
      .blink_phase (req_blink_phase),
      .item        (front_item)
   );

   vcpg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (front_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   vcpg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .monochrome     (cfg_ff.monochrome),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule
`default_nettype wire

### verif/vcpg_check_pkg.sv
`timescale 1ns / 1ps
package vcpg_check_pkg;
   import vcpg_pkg::*;

   // mode_control bits
   localparam logic [7:0] MODE_GFX320 = 8'h02;
   localparam logic [7:0] MODE_BURST  = 8'h04;
   localparam logic [7:0] MODE_ENABLE = 8'h08;
   localparam logic [7:0] MODE_GFX640 = 8'h10;
   localparam logic [7:0] MODE_BLINK  = 8'h20;
   // color_select bits
   localparam logic [7:0] CSEL_INTENSITY = 8'h10;
   localparam logic [7:0] CSEL_PALETTE   = 8'h20;
   // mode_control_two bits
   localparam logic [7:0] MC2_UNDERLINE = 8'h40;

   localparam logic [3:0] UNDERLINE_ROW = 4'd14;
   localparam int         MAX_PRINTED   = 40;

   // entry 15 first
   localparam logic [15:0][23:0] RGBI_LUT = {
      24'hffffff, 24'hffff55, 24'hff55ff, 24'hff5555,
      24'h55ffff, 24'h55ff55, 24'h5555ff, 24'h555555,
      24'haaaaaa, 24'haa5500, 24'haa00aa, 24'haa0000,
      24'h00aaaa, 24'h00aa00, 24'h0000aa, 24'h000000
   };
   localparam logic [15:0][7:0] GRAY_LUT = {
      8'hff, 8'he6, 8'hce, 8'hb6, 8'h9d, 8'h85, 8'h6d, 8'h55,
      8'haa, 8'h90, 8'h78, 8'h60, 8'h48, 8'h30, 8'h18, 8'h00
   };

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] font_row;
      logic [3:0] scan_row;
      logic       cursor_here;
      logic [7:0] cursor_bits;
      logic       blink_phase;
   } cell_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } pixel_type;

   class pixel_stream_checker;
      cfg_type   cfg;
      pixel_type expected_pixels[$];
      int        mismatches;
      int        pixels_checked;
      int        blank_cells;
      int        text_cells;
      int        narrow_cells;
      int        wide_cells;

      function new();
         cfg = '0;
      endfunction

      function void set_register(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_MODE_CONTROL:     cfg.mode_control = value;
            CSR_COLOR_SELECT:     cfg.color_select = value;
            CSR_MODE_CONTROL_TWO: cfg.mode_control_two = value;
            CSR_MONOCHROME:       cfg.monochrome = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void push_pixel(logic [3:0] color, bit last);
         pixel_type p;
         if (cfg.monochrome)
            p = {GRAY_LUT[color], GRAY_LUT[color], GRAY_LUT[color], last};
         else
            p = {RGBI_LUT[color], last};
         expected_pixels.push_back(p);
      endfunction

      // works out the pixels of one accepted cell
      function void note_cell(cell_type c);
         logic [15:0] data;
         logic [7:0]  attr;
         logic [7:0]  lit;
         logic [3:0]  color;
         logic [1:0]  idx;
         logic        underline;
         data = {c.first_byte, c.second_byte};
         if ((cfg.mode_control & MODE_ENABLE) == 0) begin
            // color 0 is black in both tables
            blank_cells++;
            for (int j = 0; j < 8; j++)
               push_pixel(4'd0, j == 7);
         end else if ((cfg.mode_control & MODE_GFX320) != 0 &&
                      (cfg.mode_control & MODE_GFX640) != 0) begin
            wide_cells++;
            for (int j = 0; j < 16; j++)
               push_pixel(data[15 - j] ? cfg.color_select[3:0] : 4'd0, j == 15);
         end else if ((cfg.mode_control & MODE_GFX320) != 0) begin
            narrow_cells++;
            for (int j = 0; j < 8; j++) begin
               idx = data[15 - 2 * j -: 2];
               if (idx == 2'd0) begin
                  color = cfg.color_select[3:0];
               end else begin
                  if ((cfg.mode_control & MODE_BURST) != 0)
                     color = (idx == 2'd1) ? 4'd3 : (idx == 2'd2) ? 4'd4 : 4'd7;
                  else if ((cfg.color_select & CSEL_PALETTE) != 0)
                     color = (idx == 2'd1) ? 4'd3 : (idx == 2'd2) ? 4'd5 : 4'd7;
                  else
                     color = (idx == 2'd1) ? 4'd2 : (idx == 2'd2) ? 4'd4 : 4'd6;
                  if ((cfg.color_select & CSEL_INTENSITY) != 0)
                     color = color + 4'd8;
               end
               push_pixel(color, j == 7);
            end
         end else begin
            text_cells++;
            attr = c.second_byte;
            lit = c.font_row;
            underline = (cfg.monochrome && (cfg.mode_control & MODE_BURST) != 0) ||
                        (cfg.mode_control_two & MC2_UNDERLINE) != 0;
            if ((cfg.mode_control & MODE_BLINK) != 0 && attr[7]) begin
               // hidden phase paints foreground with the background bits
               if (!c.blink_phase)
                  attr = (attr & 8'h70) | ((attr >> 4) & 8'h07);
               attr[7] = 1'b0;
            end
            if (underline && attr[2:0] == 3'd1) begin
               if (cfg.monochrome)
                  attr[2:0] = 3'd7;
               if (c.scan_row == UNDERLINE_ROW)
                  lit = 8'hff;
            end
            if (c.cursor_here && c.blink_phase)
               lit = lit | c.cursor_bits;
            for (int j = 0; j < 8; j++)
               push_pixel(lit[7 - j] ? attr[3:0] : attr[7:4], j == 7);
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED)
            $display("pixel mismatch: %s", msg);
      endtask

      task check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("rgb %h %h %h last %b with nothing expected",
                                      got.red, got.green, got.blue, got.last_pixel));
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("got rgb %h %h %h last %b, want rgb %h %h %h last %b",
                                      got.red, got.green, got.blue, got.last_pixel,
                                      want.red, want.green, want.blue, want.last_pixel));
      endtask
   endclass

endpackage

### verif/tb_video_cell_pixel_generator_unit.sv
`timescale 1ns / 1ps
module tb_video_cell_pixel_generator_unit;
   import vcpg_pkg::*;
   import vcpg_check_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int RANDOM_PHASES   = 16;
   localparam int CELLS_PER_PHASE = 25;
   localparam int HOLD_OFF_LENGTH = 300;
   localparam int QUIET_CYCLES    = 32;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_first_byte = '0;
   logic [7:0] req_second_byte = '0;
   logic [7:0] req_font_row = '0;
   logic [3:0] req_scan_row = '0;
   logic       req_cursor_here = 1'b0;
   logic [7:0] req_cursor_bits = '0;
   logic       req_blink_phase = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       rsp_last_pixel;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_write_data = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_cycles = 0;
   int cycle_count = 0;
   int config_count = 0;

   pixel_stream_checker pixel_checker = new();

   video_cell_pixel_generator_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d pixels outstanding",
                  cycle_count, pixel_checker.pending());
         $display("status: fail");
         $finish;
      end
   end

   // result side: check each transaction, then decide ready for the next edge
   initial begin
      pixel_type got;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_red, rsp_green, rsp_blue, rsp_last_pixel};
            pixel_checker.check_pixel(got);
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic cell_type make_cell(input logic [7:0] hi, input logic [7:0] lo,
                                          input logic [7:0] font, input logic [3:0] row,
                                          input logic here, input logic [7:0] cbits,
                                          input logic phase);
      return '{hi, lo, font, row, here, cbits, phase};
   endfunction

   // called at a clock edge; valid stays high after acceptance for back-to-back cells
   task automatic send_cell(input cell_type c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_first_byte <= c.first_byte;
      req_second_byte <= c.second_byte;
      req_font_row <= c.font_row;
      req_scan_row <= c.scan_row;
      req_cursor_here <= c.cursor_here;
      req_cursor_bits <= c.cursor_bits;
      req_blink_phase <= c.blink_phase;
      do @(posedge clock); while (!req_ready);
      pixel_checker.note_cell(c);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      pixel_checker.set_register(idx, value);
   endtask

   // drains every pending pixel before touching the registers
   task automatic apply_config(input logic [7:0] mode, input logic [7:0] colors,
                               input logic [7:0] mode_two, input logic [7:0] mono);
      req_valid <= 1'b0;
      do @(posedge clock); while (pixel_checker.pending() != 0);
      write_register(CSR_MODE_CONTROL, mode);
      write_register(CSR_COLOR_SELECT, colors);
      write_register(CSR_MODE_CONTROL_TWO, mode_two);
      write_register(CSR_MONOCHROME, mono);
      csr_write_enable <= 1'b0;
      config_count++;
   endtask

   initial begin
      cell_type   c;
      logic [7:0] mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: display off
      send_cell(make_cell(8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));
      send_cell(make_cell(8'hff, 8'hff, 8'hff, 4'd15, 1'b1, 8'hff, 1'b1));

      // plain text, cursor shown and hidden
      apply_config(MODE_ENABLE, 8'h00, 8'h00, 8'h00);
      send_cell(make_cell(8'h00, 8'h1e, 8'ha5, 4'd3, 1'b0, 8'h00, 1'b1));
      send_cell(make_cell(8'h00, 8'h8f, 8'h00, 4'd5, 1'b1, 8'h0f, 1'b1));
      send_cell(make_cell(8'h00, 8'h07, 8'h00, 4'd5, 1'b1, 8'hff, 1'b0));

      // blinking attribute in both phases
      apply_config(MODE_ENABLE | MODE_BLINK, 8'h00, 8'h00, 8'h00);
      send_cell(make_cell(8'h00, 8'h9c, 8'hf0, 4'd2, 1'b0, 8'h00, 1'b0));
      send_cell(make_cell(8'h00, 8'h9c, 8'hf0, 4'd2, 1'b1, 8'h81, 1'b1));

      // forced underline in color
      apply_config(MODE_ENABLE, 8'h00, MC2_UNDERLINE, 8'h00);
      send_cell(make_cell(8'h00, 8'h01, 8'h00, UNDERLINE_ROW, 1'b0, 8'h00, 1'b1));
      send_cell(make_cell(8'h00, 8'h01, 8'h3c, 4'd13, 1'b0, 8'h00, 1'b1));

      // mono underline through colour burst, with blink
      apply_config(MODE_ENABLE | MODE_BURST | MODE_BLINK, 8'h00, 8'h00, 8'h01);
      send_cell(make_cell(8'h00, 8'h81, 8'h00, UNDERLINE_ROW, 1'b0, 8'h00, 1'b0));
      send_cell(make_cell(8'h00, 8'h09, 8'h18, UNDERLINE_ROW, 1'b0, 8'h00, 1'b1));
      send_cell(make_cell(8'h00, 8'h71, 8'h00, 4'd12, 1'b0, 8'h00, 1'b1));

      // 320 mode, every palette flavor
      apply_config(MODE_ENABLE | MODE_GFX320, 8'h00, 8'h00, 8'h00);
      send_cell(make_cell(8'h1b, 8'he4, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));
      apply_config(MODE_ENABLE | MODE_GFX320, 8'h3f, 8'h00, 8'h00);
      send_cell(make_cell(8'h1b, 8'he4, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));
      apply_config(MODE_ENABLE | MODE_GFX320 | MODE_BURST, 8'h1a, 8'h00, 8'h01);
      send_cell(make_cell(8'he4, 8'h1b, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));

      // 640 mode
      apply_config(MODE_ENABLE | MODE_GFX320 | MODE_GFX640, 8'h0f, 8'h00, 8'h00);
      send_cell(make_cell(8'hff, 8'h00, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));
      send_cell(make_cell(8'ha5, 8'h5a, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));
      apply_config(MODE_ENABLE | MODE_GFX320 | MODE_GFX640, 8'h07, 8'h00, 8'h01);
      send_cell(make_cell(8'h80, 8'h01, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));

      // 640 select without the graphics bit stays text
      apply_config(MODE_ENABLE | MODE_GFX640, 8'hff, 8'h00, 8'h00);
      send_cell(make_cell(8'h00, 8'h4f, 8'h81, 4'd0, 1'b0, 8'h00, 1'b1));

      // all ones, then display off in mono
      apply_config(8'hff, 8'hff, 8'hff, 8'hff);
      send_cell(make_cell(8'hff, 8'hff, 8'hff, 4'd15, 1'b1, 8'hff, 1'b1));
      apply_config(8'h00, 8'h00, 8'h00, 8'h01);
      send_cell(make_cell(8'h5a, 8'ha5, 8'hff, UNDERLINE_ROW, 1'b1, 8'hff, 1'b1));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = 8'($urandom_range(255));
         if ($urandom_range(99) < 85)
            mode = mode | MODE_ENABLE;
         apply_config(mode, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 63; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 63; end
            default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
         endcase
         // long receiver hold-off while cells keep coming, so the input backs up
         if (p == 5) begin
            send_idle_pct = 0;
            hold_off_cycles = HOLD_OFF_LENGTH;
         end
         for (int k = 0; k < CELLS_PER_PHASE; k++) begin
            // sender waits for the pipeline to empty mid-phase
            if (p == 9 && k == CELLS_PER_PHASE / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pixel_checker.pending() != 0);
            end
            c.first_byte = 8'($urandom_range(255));
            c.second_byte = 8'($urandom_range(255));
            if ($urandom_range(3) == 0)
               c.second_byte[2:0] = 3'd1;
            c.font_row = 8'($urandom_range(255));
            c.scan_row = ($urandom_range(2) == 0) ? UNDERLINE_ROW : 4'($urandom_range(15));
            c.cursor_here = 1'($urandom_range(1));
            c.cursor_bits = 8'($urandom_range(255));
            c.blink_phase = 1'($urandom_range(1));
            send_cell(c);
         end
      end

      req_valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_cycles = 0;
      do @(posedge clock); while (pixel_checker.pending() != 0);
      repeat (QUIET_CYCLES) @(posedge clock);

      $display("cells sent: %0d blank, %0d text, %0d 320-wide, %0d 640-wide, %0d register setups",
               pixel_checker.blank_cells, pixel_checker.text_cells,
               pixel_checker.narrow_cells, pixel_checker.wide_cells, config_count);
      $display("pixels compared: %0d, mismatches: %0d",
               pixel_checker.pixels_checked, pixel_checker.mismatches);
      if (pixel_checker.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
